### rtl/core/tcf_pkg.sv
// shared types and constants for the two-class fifo with oldest-first dequeue
// depends on nothing; used by every module in rtl/core
`timescale 1ns / 1ps

package tcf_pkg;

   // default sizes, handed to the top level parameters
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TAG_BITS_DEF    = 16;

   // arrival stamps are fixed at six bits
   localparam int STAMP_BITS = 6;

   // operation codes of a request
   typedef enum logic [1:0] {
      OP_ENQ      = 2'd0,
      OP_DEQ_ANY  = 2'd1,
      OP_DEQ_ZERO = 2'd2,
      OP_DEQ_ONE  = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

endpackage

### rtl/core/tcf_mem.sv
// one queue store: synchronous ram holding stamp and tag per entry
// one write port, one read port with registered data; uses tcf_pkg
`timescale 1ns / 1ps

module tcf_mem #(
   parameter int QUEUE_DEPTH = tcf_pkg::QUEUE_DEPTH_DEF,
   parameter int DATA_BITS   = tcf_pkg::STAMP_BITS + tcf_pkg::TAG_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
   input  logic [DATA_BITS-1:0]           wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
   output logic [DATA_BITS-1:0]           rd_data
);
   import tcf_pkg::*;

   logic [DATA_BITS-1:0] mem_ff [QUEUE_DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data registered when rd_en is high
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/tcf_seq.sv
// request sequencer: head and count pointers, arrival counter, age pick
// drives the two queue stores and the result register; uses tcf_pkg
`timescale 1ns / 1ps

module tcf_seq #(
   parameter int QUEUE_DEPTH = tcf_pkg::QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = tcf_pkg::TAG_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // request channel
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic [1:0]                                  req_operation,
   input  logic                                        req_item_class,
   input  logic [TAG_BITS-1:0]                         req_item_tag,
   // result channel
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [1:0]                                  rsp_status,
   output logic [TAG_BITS-1:0]                         rsp_out_tag,
   output logic                                        rsp_out_class,
   // queue stores, index 0 is class zero
   output logic [1:0]                                  mem_wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0]              mem_wr_addr,
   output logic [tcf_pkg::STAMP_BITS+TAG_BITS-1:0]     mem_wr_data,
   output logic                                        mem_rd_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0]              mem_rd_addr0,
   output logic [$clog2(QUEUE_DEPTH)-1:0]              mem_rd_addr1,
   input  logic [tcf_pkg::STAMP_BITS+TAG_BITS-1:0]     mem_rd_data0,
   input  logic [tcf_pkg::STAMP_BITS+TAG_BITS-1:0]     mem_rd_data1
);
   import tcf_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = AW + 1;

   typedef enum logic {
      S_IDLE,
      S_EVAL
   } state_type;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic                  class_ff, class_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic [AW-1:0]         head0_ff, head0_in, head1_ff, head1_in;
   logic [CW-1:0]         count0_ff, count0_in, count1_ff, count1_in;
   logic [STAMP_BITS-1:0] arrival_ff, arrival_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [TAG_BITS-1:0]   rsp_tag_ff, rsp_tag_in;
   logic                  rsp_class_ff, rsp_class_in;

   logic                  accept;
   logic                  finish;
   logic [AW-1:0]         enq_head;
   logic [CW-1:0]         enq_count;
   logic [SW-1:0]         slot_sum;
   logic [AW-1:0]         slot;
   logic [STAMP_BITS-1:0] stamp0, stamp1, stamp_diff;
   logic                  take_none;
   logic                  take_class;
   logic [AW-1:0]         take_head;
   logic [AW-1:0]         take_head_next;

   // handshake: no request during reset, one in flight; result register parts the two sides
   assign req_stall = reset || (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign finish    = (state_ff == S_EVAL) && (!rsp_valid_ff || !rsp_stall);

   // both heads are read as the request is taken; data is back in S_EVAL
   assign mem_rd_en    = accept;
   assign mem_rd_addr0 = head0_ff;
   assign mem_rd_addr1 = head1_ff;

   // enqueue slot: head plus count, wrapped once
   assign enq_head  = class_ff ? head1_ff : head0_ff;
   assign enq_count = class_ff ? count1_ff : count0_ff;
   assign slot_sum  = SW'(enq_head) + SW'(enq_count);
   assign slot      = (slot_sum >= SW'(QUEUE_DEPTH)) ? AW'(slot_sum - SW'(QUEUE_DEPTH))
                                                      : AW'(slot_sum);

   // age of the two heads by the sign of the modular stamp difference
   assign stamp0     = mem_rd_data0[STAMP_BITS+TAG_BITS-1:TAG_BITS];
   assign stamp1     = mem_rd_data1[STAMP_BITS+TAG_BITS-1:TAG_BITS];
   assign stamp_diff = stamp0 - stamp1;

   // pick the class to dequeue
   always_comb begin
      take_none  = 1'b0;
      take_class = 1'b0;
      unique case (op_ff)
         OP_DEQ_ANY: begin
            if (count0_ff == '0 && count1_ff == '0) begin
               take_none = 1'b1;
            end else if (count0_ff == '0) begin
               take_class = 1'b1;
            end else if (count1_ff == '0) begin
               take_class = 1'b0;
            end else begin
               take_class = !stamp_diff[STAMP_BITS-1];
            end
         end
         OP_DEQ_ZERO: begin
            take_none  = (count0_ff == '0);
            take_class = 1'b0;
         end
         OP_DEQ_ONE: begin
            take_none  = (count1_ff == '0);
            take_class = 1'b1;
         end
         default: begin
            take_none  = 1'b0;
            take_class = 1'b0;
         end
      endcase
   end

   assign take_head      = take_class ? head1_ff : head0_ff;
   assign take_head_next = (take_head == AW'(QUEUE_DEPTH - 1)) ? '0 : take_head + AW'(1);

   // store write for an enqueue that fits
   always_comb begin
      mem_wr_en   = 2'b00;
      mem_wr_addr = slot;
      mem_wr_data = {arrival_ff, tag_ff};
      if (finish && op_ff == OP_ENQ && enq_count != CW'(QUEUE_DEPTH)) begin
         mem_wr_en[class_ff] = 1'b1;
      end
   end

   // next state of pointers, sequencer and result register
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      class_in      = class_ff;
      tag_in        = tag_ff;
      head0_in      = head0_ff;
      head1_in      = head1_ff;
      count0_in     = count0_ff;
      count1_in     = count1_ff;
      arrival_in    = arrival_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_class_in  = rsp_class_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = op_type'(req_operation);
               class_in = req_item_class;
               tag_in   = req_item_tag;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (finish) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_tag_in   = '0;
               rsp_class_in = 1'b0;
               if (op_ff == OP_ENQ) begin
                  if (enq_count == CW'(QUEUE_DEPTH)) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     rsp_status_in = STAT_OK;
                     arrival_in    = arrival_ff + STAMP_BITS'(1);
                     if (class_ff) begin
                        count1_in = count1_ff + CW'(1);
                     end else begin
                        count0_in = count0_ff + CW'(1);
                     end
                  end
               end else if (take_none) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  rsp_status_in = STAT_OK;
                  rsp_class_in  = take_class;
                  if (take_class) begin
                     rsp_tag_in = mem_rd_data1[TAG_BITS-1:0];
                     head1_in   = take_head_next;
                     count1_in  = count1_ff - CW'(1);
                  end else begin
                     rsp_tag_in = mem_rd_data0[TAG_BITS-1:0];
                     head0_in   = take_head_next;
                     count0_in  = count0_ff - CW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head0_ff     <= '0;
         head1_ff     <= '0;
         count0_ff    <= '0;
         count1_ff    <= '0;
         arrival_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head0_ff     <= head0_in;
         head1_ff     <= head1_in;
         count0_ff    <= count0_in;
         count1_ff    <= count1_in;
         arrival_ff   <= arrival_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      class_ff      <= class_in;
      tag_ff        <= tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_class_ff  <= rsp_class_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_tag   = rsp_tag_ff;
   assign rsp_out_class = rsp_class_ff;

endmodule

### rtl/core/two_class_fifo_oldest_first.sv
// top level of the two-class fifo with global age order
// instantiates tcf_seq and two tcf_mem stores; uses tcf_pkg
`timescale 1ns / 1ps
//
//  channel   handshake              payload
//  -------   --------------------   -----------------------------------------
//  req       req_valid / req_stall  req_operation, req_item_class, req_item_tag
//  rsp       rsp_valid / rsp_stall  rsp_status, rsp_out_tag, rsp_out_class
//
//  every request is taken in S_IDLE and finished in S_EVAL: the heads of both
//  queue rams are read as the request is taken, and the read data comes back in
//  S_EVAL, where the result is registered and the pointers and ram are updated.
//  a new request is taken in the cycle after the result is registered, so the
//  block takes no new request until the result of the last one is registered.
//  a stalled result holds the sequencer in S_EVAL until it is taken.
//  reset clears pointers, counts and the arrival counter; the rams are not
//  cleared, as no entry's contents are used before the entry is written.
//
module two_class_fifo_oldest_first #(
   parameter int QUEUE_DEPTH = tcf_pkg::QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = tcf_pkg::TAG_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_operation,
   input  logic                req_item_class,
   input  logic [TAG_BITS-1:0] req_item_tag,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [TAG_BITS-1:0] rsp_out_tag,
   output logic                rsp_out_class
);
   import tcf_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int DW = STAMP_BITS + TAG_BITS;

   logic [1:0]    mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [DW-1:0] mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr0, mem_rd_addr1;
   logic [DW-1:0] mem_rd_data0, mem_rd_data1;

   // sequencer
   tcf_seq #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .TAG_BITS   (TAG_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_item_class(req_item_class),
      .req_item_tag  (req_item_tag),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_out_tag   (rsp_out_tag),
      .rsp_out_class (rsp_out_class),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr0  (mem_rd_addr0),
      .mem_rd_addr1  (mem_rd_addr1),
      .mem_rd_data0  (mem_rd_data0),
      .mem_rd_data1  (mem_rd_data1)
   );

   // class zero store
   tcf_mem #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .DATA_BITS  (DW)
   ) u_mem_zero (
      .clock  (clock),
      .wr_en  (mem_wr_en[0]),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr0),
      .rd_data(mem_rd_data0)
   );

   // class one store
   tcf_mem #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .DATA_BITS  (DW)
   ) u_mem_one (
      .clock  (clock),
      .wr_en  (mem_wr_en[1]),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr1),
      .rd_data(mem_rd_data1)
   );

endmodule

### rtl/core/tcf_chk.sv
// port-level checks on the two-class fifo, bound to the top level
// depends on tcf_pkg and two_class_fifo_oldest_first
`timescale 1ns / 1ps

module tcf_chk #(
   parameter int TAG_BITS = tcf_pkg::TAG_BITS_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [1:0]          rsp_status,
   input logic [TAG_BITS-1:0] rsp_out_tag,
   input logic                rsp_out_class
);
   import tcf_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_tag) && $stable(rsp_out_class))
      else $error("stalled result changed");

   // only one request is in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in flight");

   // a fresh result follows a taken request
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a request");

   // a failed request carries no item
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_out_tag == '0 && rsp_out_class == 1'b0)
      else $error("failed request returned an item");

endmodule

bind two_class_fifo_oldest_first tcf_chk #(
   .TAG_BITS(TAG_BITS)
) u_tcf_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_out_tag  (rsp_out_tag),
   .rsp_out_class(rsp_out_class)
);
